### rtl/core/fjt_pkg.sv
// ---------------------------------------------------------------------------
// fjt_pkg
// Shared types and constants for the flat JSON pair tokenizer.
// ---------------------------------------------------------------------------
package fjt_pkg;

  localparam int BODY_LIMIT = 4096;
  localparam int POS_W      = $clog2(BODY_LIMIT) + 1;
  localparam int OFS_W      = 12;
  localparam int CNT_W      = 8;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [CNT_W-1:0] PAIR_LIMIT_RESET = 8'd16;

  typedef enum logic [7:0] {
    PH_OPEN     = 8'b0000_0001,
    PH_KEYQ     = 8'b0000_0010,
    PH_KEY      = 8'b0000_0100,
    PH_COLON    = 8'b0000_1000,
    PH_VALSTART = 8'b0001_0000,
    PH_STRVAL   = 8'b0010_0000,
    PH_BARE     = 8'b0100_0000,
    PH_AFTER    = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLOSED    = 3'd0,
    ST_LIMIT     = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_ENDED     = 3'd3,
    ST_TOOLONG   = 3'd4
  } status_t;

  typedef struct packed {
    logic             pair_valid;
    logic [OFS_W-1:0] key_start;
    logic [OFS_W-1:0] key_length;
    logic [OFS_W-1:0] value_start;
    logic [OFS_W-1:0] value_length;
    logic             value_is_string;
    logic [CNT_W-1:0] pair_index;
    logic             final_res;
    logic [CNT_W-1:0] pair_count;
    status_t          status;
  } item_t;

  typedef struct packed {
    logic  pair_we;
    logic  final_we;
    item_t pair_item;
    item_t final_item;
  } wr_req_t;

endpackage

### rtl/core/fjt_cfg.sv
// ---------------------------------------------------------------------------
// fjt_cfg
// APB register file holding the pair limit.
// ---------------------------------------------------------------------------
module fjt_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [fjt_pkg::CNT_W-1:0] pair_limit
);
  import fjt_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_limit <= PAIR_LIMIT_RESET;
    end else if (wr_en) begin
      pair_limit <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, pair_limit} : 32'd0;

endmodule

### rtl/core/fjt_parser.sv
// ---------------------------------------------------------------------------
// fjt_parser
// Parse state and per-byte next-state logic; yields up to two result items
// (a pair, then the summary) for each accepted byte.
// ---------------------------------------------------------------------------
module fjt_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                data_byte,
  input  logic                      is_last,
  input  logic [fjt_pkg::CNT_W-1:0] pair_limit,
  output fjt_pkg::wr_req_t          wr_req
);
  import fjt_pkg::*;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] pairs, pairs_next, pairs_after;
  logic [OFS_W-1:0] key_start, key_start_next;
  logic [OFS_W-1:0] key_len, key_len_next;
  logic [OFS_W-1:0] val_start, val_start_next;
  logic [OFS_W-1:0] lne, lne_next;
  logic             stopped, stopped_next;

  logic             ws, is_nul;
  logic [OFS_W-1:0] pos_ofs;
  logic             do_pair, do_fin, do_term, do_comma;
  logic [OFS_W-1:0] pair_vlen;
  logic             pair_str;
  status_t          fin_status;

  assign is_nul  = (data_byte == CH_NUL);
  assign ws      = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
  assign pos_ofs = pos[OFS_W-1:0];

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    key_start_next = key_start;
    key_len_next   = key_len;
    val_start_next = val_start;
    lne_next       = lne;
    do_pair        = 1'b0;
    do_fin         = 1'b0;
    do_term        = 1'b0;
    do_comma       = 1'b0;
    pair_vlen      = '0;
    pair_str       = 1'b0;
    fin_status     = ST_CLOSED;
    pairs_after    = pairs;

    if (!stopped) begin
      if (pos >= POS_W'(BODY_LIMIT)) begin
        do_fin     = 1'b1;
        fin_status = ST_TOOLONG;
      end else begin
        pos_next = pos + POS_W'(1);
        case (phase)
          PH_OPEN: begin
            if (is_nul) begin
              do_fin     = 1'b1;
              fin_status = ST_ENDED;
            end else if (ws) begin
            end else if (data_byte == CH_OPEN) begin
              do_comma = 1'b1;
            end else begin
              do_fin     = 1'b1;
              fin_status = ST_MALFORMED;
            end
          end
          PH_KEYQ: begin
            if (is_nul) begin
              do_fin     = 1'b1;
              fin_status = ST_ENDED;
            end else if (ws) begin
            end else if (data_byte == CH_CLOSE) begin
              do_fin     = 1'b1;
              fin_status = ST_CLOSED;
            end else if (data_byte == CH_QUOTE) begin
              key_start_next = pos_ofs + OFS_W'(1);
              phase_next     = PH_KEY;
            end else begin
              do_fin     = 1'b1;
              fin_status = ST_MALFORMED;
            end
          end
          PH_KEY: begin
            if (is_nul) begin
              do_fin     = 1'b1;
              fin_status = ST_ENDED;
            end else if (data_byte == CH_QUOTE) begin
              key_len_next = pos_ofs - key_start;
              phase_next   = PH_COLON;
            end
          end
          PH_COLON: begin
            if (is_nul) begin
              do_fin     = 1'b1;
              fin_status = ST_ENDED;
            end else if (ws) begin
            end else if (data_byte == CH_COLON) begin
              phase_next = PH_VALSTART;
            end else begin
              do_fin     = 1'b1;
              fin_status = ST_MALFORMED;
            end
          end
          PH_VALSTART: begin
            if (ws) begin
            end else if (data_byte == CH_QUOTE) begin
              val_start_next = pos_ofs + OFS_W'(1);
              phase_next     = PH_STRVAL;
            end else if (data_byte == CH_COMMA || data_byte == CH_CLOSE || is_nul) begin
              val_start_next = pos_ofs;
              do_pair        = 1'b1;
              phase_next     = PH_AFTER;
              do_term        = 1'b1;
            end else begin
              val_start_next = pos_ofs;
              lne_next       = pos_ofs + OFS_W'(1);
              phase_next     = PH_BARE;
            end
          end
          PH_STRVAL: begin
            if (is_nul) begin
              do_fin     = 1'b1;
              fin_status = ST_ENDED;
            end else if (data_byte == CH_QUOTE) begin
              do_pair    = 1'b1;
              pair_vlen  = pos_ofs - val_start;
              pair_str   = 1'b1;
              phase_next = PH_AFTER;
            end
          end
          PH_BARE: begin
            if (data_byte == CH_COMMA || data_byte == CH_CLOSE || is_nul) begin
              do_pair    = 1'b1;
              pair_vlen  = lne - val_start;
              phase_next = PH_AFTER;
              do_term    = 1'b1;
            end else if (!ws) begin
              lne_next = pos_ofs + OFS_W'(1);
            end
          end
          PH_AFTER: begin
            if (!ws) begin
              do_term = 1'b1;
            end
          end
          default: begin
            do_term = 1'b1;
          end
        endcase

        pairs_after = pairs + CNT_W'(do_pair);

        if (do_term) begin
          if (data_byte == CH_COMMA) begin
            do_comma = 1'b1;
          end else if (data_byte == CH_CLOSE) begin
            do_fin     = 1'b1;
            fin_status = ST_CLOSED;
          end else if (is_nul) begin
            do_fin     = 1'b1;
            fin_status = ST_ENDED;
          end else begin
            do_fin     = 1'b1;
            fin_status = ST_MALFORMED;
          end
        end

        if (do_comma) begin
          if (pairs_after >= pair_limit) begin
            do_fin     = 1'b1;
            fin_status = ST_LIMIT;
          end else begin
            phase_next = PH_KEYQ;
          end
        end
      end

      // body ends without a stop: flush an open bare value, then summarise
      if (!do_fin && is_last) begin
        if (phase_next == PH_VALSTART) begin
          val_start_next = pos_next[OFS_W-1:0];
          do_pair        = 1'b1;
          pair_vlen      = '0;
          pair_str       = 1'b0;
        end else if (phase_next == PH_BARE) begin
          do_pair   = 1'b1;
          pair_vlen = lne_next - val_start_next;
          pair_str  = 1'b0;
        end
        do_fin     = 1'b1;
        fin_status = ST_ENDED;
      end
    end

    pairs_next   = pairs + CNT_W'(do_pair);
    stopped_next = stopped | do_fin;

    wr_req.pair_we                    = accept && do_pair;
    wr_req.final_we                   = accept && do_fin;
    wr_req.pair_item                  = '0;
    wr_req.pair_item.pair_valid       = 1'b1;
    wr_req.pair_item.key_start        = key_start_next;
    wr_req.pair_item.key_length       = key_len_next;
    wr_req.pair_item.value_start      = val_start_next;
    wr_req.pair_item.value_length     = pair_vlen;
    wr_req.pair_item.value_is_string  = pair_str;
    wr_req.pair_item.pair_index       = pairs;
    wr_req.pair_item.status           = ST_CLOSED;
    wr_req.final_item                 = '0;
    wr_req.final_item.final_res       = 1'b1;
    wr_req.final_item.pair_count      = pairs_next;
    wr_req.final_item.status          = fin_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OPEN;
      pos       <= '0;
      pairs     <= '0;
      key_start <= '0;
      key_len   <= '0;
      val_start <= '0;
      lne       <= '0;
      stopped   <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        phase     <= PH_OPEN;
        pos       <= '0;
        pairs     <= '0;
        key_start <= '0;
        key_len   <= '0;
        val_start <= '0;
        lne       <= '0;
        stopped   <= 1'b0;
      end else begin
        phase     <= phase_next;
        pos       <= pos_next;
        pairs     <= pairs_next;
        key_start <= key_start_next;
        key_len   <= key_len_next;
        val_start <= val_start_next;
        lne       <= lne_next;
        stopped   <= stopped_next;
      end
    end
  end

endmodule

### rtl/core/fjt_out_queue.sv
// ---------------------------------------------------------------------------
// fjt_out_queue
// Four-entry result queue; takes up to two items a cycle, hands out one.
// ---------------------------------------------------------------------------
module fjt_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  fjt_pkg::wr_req_t wr_req,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output fjt_pkg::item_t   out_item
);
  import fjt_pkg::*;

  item_t       entries [4];
  logic [1:0]  wp, rp, wp_second;
  logic [2:0]  count;
  logic        pop;
  logic [2:0]  n_wr;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_item  = entries[rp];
  assign room      = (count <= 3'd2);
  assign n_wr      = 3'(wr_req.pair_we) + 3'(wr_req.final_we);
  assign wp_second = wp + 2'(wr_req.pair_we);

  always_ff @(posedge clk) begin
    if (wr_req.pair_we) begin
      entries[wp] <= wr_req.pair_item;
    end
    if (wr_req.final_we) begin
      entries[wp_second] <= wr_req.final_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + n_wr[1:0];
      rp    <= rp + 2'(pop);
      count <= count + n_wr - 3'(pop);
    end
  end

endmodule

### rtl/core/flat_json_pair_tokenizer_core.sv
// ---------------------------------------------------------------------------
// flat_json_pair_tokenizer_core
// Streams a body byte by byte and reports key/value pairs of a flat JSON
// object, followed by one summary transaction per body.
// ---------------------------------------------------------------------------
//  channel  | direction | carries
//  s_*      | in        | one body byte per transaction, tlast = is_last
//  m_*      | out       | pair or summary item, tuser = pair_valid, tlast = final_res
//  apb      | in        | pair limit at byte address 0
//
//  One byte is taken per cycle while s_tready is high; the parse step is combinational from the
//  parse state registers into a four-entry result queue.
//  A byte yields zero, one or two result transactions; s_tready drops while
//  the queue holds more than two items, so a stalled m_tready throttles input.
//  Reset is synchronous; it clears the parse state, the queue and restores
//  the pair limit to 16. No clearing pass.
// ---------------------------------------------------------------------------
module flat_json_pair_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // key_start, key_length, value_start,
                                 // value_length, value_is_string, pair_index,
                                 // pair_count, status, zero pad
  output logic [0:0]  m_tuser,   // [0] pair_valid
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fjt_pkg::*;

  logic             accept;
  logic             room;
  logic [CNT_W-1:0] pair_limit;
  wr_req_t          wr_req;
  item_t            out_item;

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  fjt_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pair_limit (pair_limit)
  );

  fjt_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .is_last    (s_tlast),
    .pair_limit (pair_limit),
    .wr_req     (wr_req)
  );

  fjt_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_req    (wr_req),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {4'd0,
                    out_item.status,
                    out_item.pair_count,
                    out_item.pair_index,
                    out_item.value_is_string,
                    out_item.value_length,
                    out_item.value_start,
                    out_item.key_length,
                    out_item.key_start};
  assign m_tuser = out_item.pair_valid;
  assign m_tlast = out_item.final_res;

endmodule

### tb/fjt_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fjt_checker
// Watches the byte, result and register channels of the flat JSON pair
// tokenizer. Keeps its own copy of the parse state, predicts the pair and
// summary transactions each accepted byte causes, and compares every
// accepted result with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module fjt_checker
  import fjt_pkg::*;
#(
  parameter logic [2:0] PAIR_LIMIT_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending
);

  phase_t      ph;
  logic [12:0] bpos;
  logic [7:0]  npairs;
  logic [12:0] kstart;
  logic [12:0] klen;
  logic [12:0] vstart;
  logic [12:0] vend;
  logic        halted;
  logic [7:0]  pair_limit;
  item_t       pair_items[$];

  function automatic logic is_space(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  task automatic report(input string what, input logic [11:0] got, input logic [11:0] want);
    fails++;
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [11:0] got,
                             input logic [11:0] want);
    if (got !== want)
      report(what, got, want);
  endtask

  task automatic clear_parse();
    ph     = PH_OPEN;
    bpos   = '0;
    npairs = '0;
    kstart = '0;
    klen   = '0;
    vstart = '0;
    vend   = '0;
    halted = 1'b0;
  endtask

  task automatic emit_pair(input logic [12:0] len, input logic is_str);
    item_t it;
    it = '0;
    it.pair_valid      = 1'b1;
    it.key_start       = kstart[OFS_W-1:0];
    it.key_length      = klen[OFS_W-1:0];
    it.value_start     = vstart[OFS_W-1:0];
    it.value_length    = len[OFS_W-1:0];
    it.value_is_string = is_str;
    it.pair_index      = npairs;
    it.status          = ST_CLOSED;
    pair_items.push_back(it);
    npairs = npairs + 8'd1;
  endtask

  task automatic close_parse(input status_t st);
    item_t it;
    it = '0;
    it.final_res  = 1'b1;
    it.pair_count = npairs;
    it.status     = st;
    pair_items.push_back(it);
    halted = 1'b1;
  endtask

  task automatic next_key();
    if (npairs >= pair_limit)
      close_parse(ST_LIMIT);
    else
      ph = PH_KEYQ;
  endtask

  task automatic end_token(input logic [7:0] b);
    if (b == CH_COMMA)
      next_key();
    else if (b == CH_CLOSE)
      close_parse(ST_CLOSED);
    else if (b == CH_NUL)
      close_parse(ST_ENDED);
    else
      close_parse(ST_MALFORMED);
  endtask

  task automatic advance(input logic [7:0] b, input logic [12:0] p);
    case (ph)
      PH_OPEN: begin
        if (b == CH_NUL) close_parse(ST_ENDED);
        else if (is_space(b)) ;
        else if (b == CH_OPEN) next_key();
        else close_parse(ST_MALFORMED);
      end
      PH_KEYQ: begin
        if (b == CH_NUL) close_parse(ST_ENDED);
        else if (is_space(b)) ;
        else if (b == CH_CLOSE) close_parse(ST_CLOSED);
        else if (b == CH_QUOTE) begin
          kstart = p + 13'd1;
          ph     = PH_KEY;
        end else close_parse(ST_MALFORMED);
      end
      PH_KEY: begin
        if (b == CH_NUL) close_parse(ST_ENDED);
        else if (b == CH_QUOTE) begin
          klen = p - kstart;
          ph   = PH_COLON;
        end
      end
      PH_COLON: begin
        if (b == CH_NUL) close_parse(ST_ENDED);
        else if (is_space(b)) ;
        else if (b == CH_COLON) ph = PH_VALSTART;
        else close_parse(ST_MALFORMED);
      end
      PH_VALSTART: begin
        if (is_space(b)) ;
        else if (b == CH_QUOTE) begin
          vstart = p + 13'd1;
          ph     = PH_STRVAL;
        end else if (b == CH_COMMA || b == CH_CLOSE || b == CH_NUL) begin
          vstart = p;
          emit_pair('0, 1'b0);
          ph = PH_AFTER;
          end_token(b);
        end else begin
          vstart = p;
          vend   = p + 13'd1;
          ph     = PH_BARE;
        end
      end
      PH_STRVAL: begin
        if (b == CH_NUL) close_parse(ST_ENDED);
        else if (b == CH_QUOTE) begin
          emit_pair(p - vstart, 1'b1);
          ph = PH_AFTER;
        end
      end
      PH_BARE: begin
        if (b == CH_COMMA || b == CH_CLOSE || b == CH_NUL) begin
          emit_pair(vend - vstart, 1'b0);
          ph = PH_AFTER;
          end_token(b);
        end else if (!is_space(b)) begin
          vend = p + 13'd1;
        end
      end
      default: begin
        if (!is_space(b))
          end_token(b);
      end
    endcase
  endtask

  task automatic tokenize(input logic [7:0] b, input logic last);
    logic [12:0] p;
    if (!halted) begin
      p = bpos;
      if (p >= BODY_LIMIT) begin
        close_parse(ST_TOOLONG);
      end else begin
        advance(b, p);
        bpos = p + 13'd1;
      end
      if (!halted && last) begin
        if (ph == PH_VALSTART) begin
          vstart = bpos;
          emit_pair('0, 1'b0);
        end else if (ph == PH_BARE) begin
          emit_pair(vend - vstart, 1'b0);
        end
        close_parse(ST_ENDED);
      end
    end
    if (last)
      clear_parse();
  endtask

  always @(posedge clk) begin
    item_t want;
    if (rst) begin
      clear_parse();
      pair_limit = PAIR_LIMIT_RESET;
      pair_items.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == PAIR_LIMIT_ADDR)
        pair_limit = pwdata[CNT_W-1:0];
      if (s_tvalid && s_tready)
        tokenize(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (pair_items.size() == 0) begin
          report("result transaction with nothing outstanding", m_tdata[11:0], '0);
        end else begin
          want = pair_items.pop_front();
          check_field("pair_valid", 12'(m_tuser[0]), 12'(want.pair_valid));
          check_field("key_start", m_tdata[11:0], want.key_start);
          check_field("key_length", m_tdata[23:12], want.key_length);
          check_field("value_start", m_tdata[35:24], want.value_start);
          check_field("value_length", m_tdata[47:36], want.value_length);
          check_field("value_is_string", 12'(m_tdata[48]), 12'(want.value_is_string));
          check_field("pair_index", 12'(m_tdata[56:49]), 12'(want.pair_index));
          check_field("final_res", 12'(m_tlast), 12'(want.final_res));
          check_field("pair_count", 12'(m_tdata[64:57]), 12'(want.pair_count));
          check_field("status", 12'(m_tdata[67:65]), 12'(want.status));
          check_field("zero pad", 12'(m_tdata[71:68]), 12'd0);
        end
      end
    end
    pending = pair_items.size();
  end

endmodule

### tb/tb_flat_json_pair_tokenizer_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_flat_json_pair_tokenizer_core
// Streams JSON bodies into the tokenizer: a few hand-written corner cases,
// then random objects, half of them left as built with random content and the rest
// truncated, corrupted or plain noise, under several pair limit settings.
// Both stream sides idle at random.
// The checker predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_flat_json_pair_tokenizer_core;
  import fjt_pkg::*;

  localparam logic [2:0] REG_PAIR_LIMIT = 3'd0;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_BYTES = 230;
  localparam int SETTLE      = 4;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fails;
  int          pending;
  int          idle_cycles;
  logic        tx_burst;
  logic        rx_burst;
  logic [7:0]  body[$];

  flat_json_pair_tokenizer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  fjt_checker #(
    .PAIR_LIMIT_ADDR (REG_PAIR_LIMIT)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .fails    (fails),
    .pending  (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("flat_json_pair_tokenizer_core verification failed");
        $finish;
      end
    end
  end

  // result side: random back-pressure, occasionally long runs without any
  initial begin
    int stall;
    m_tready = 1'b0;
    rx_burst = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  function automatic logic [7:0] key_char();
    logic [7:0] c;
    c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(8'h30, 8'h7A));
    if (c == CH_QUOTE) c = "q";
    return c;
  endfunction

  function automatic logic [7:0] bare_char();
    logic [7:0] c;
    c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(8'h30, 8'h7A));
    if (c == CH_COMMA || c == CH_CLOSE) c = "7";
    return c;
  endfunction

  task automatic add_space();
    int k;
    repeat ($urandom_range(0, 2)) begin
      k = $urandom_range(0, 6);
      body.push_back(k == 6 ? CH_SPACE : 8'(9 + k));
    end
  endtask

  task automatic load_text(input string s);
    body.delete();
    for (int i = 0; i < s.len(); i++)
      body.push_back(s[i]);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_body();
    tx_burst = ($urandom_range(0, 5) == 0);
    foreach (body[i])
      push_byte(body[i], i == body.size() - 1);
  endtask

  task automatic set_pair_limit(input logic [7:0] v);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_PAIR_LIMIT;
    pwdata  <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // half of the objects left as built; the rest truncated, corrupted or pure noise
  task automatic make_body();
    int n;
    int kind;
    int idx;
    body.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      if ($urandom_range(0, 1) == 1) body.push_back(CH_OPEN);
      repeat ($urandom_range(1, 8)) body.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 4);
    add_space();
    body.push_back(CH_OPEN);
    for (int i = 0; i < n; i++) begin
      add_space();
      body.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 4)) body.push_back(key_char());
      body.push_back(CH_QUOTE);
      add_space();
      body.push_back(CH_COLON);
      add_space();
      case ($urandom_range(0, 4))
        0, 1: begin
          body.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 5)) body.push_back(key_char());
          body.push_back(CH_QUOTE);
        end
        2, 3: begin
          repeat ($urandom_range(1, 5)) body.push_back(bare_char());
        end
        default: ;
      endcase
      add_space();
      if (i < n - 1) body.push_back(CH_COMMA);
    end
    if (n > 0 && $urandom_range(0, 4) == 0) body.push_back(CH_COMMA);
    add_space();
    body.push_back(CH_CLOSE);
    repeat ($urandom_range(0, 2)) body.push_back(8'($urandom_range(0, 255)));
    idx = $urandom_range(0, body.size() - 1);
    case (kind)
      1: while (body.size() > idx + 1) void'(body.pop_back());
      2: body[idx] = 8'($urandom_range(0, 255));
      3: body.insert(idx, 8'($urandom_range(0, 255)));
      4: body[idx] = CH_NUL;
      default: ;
    endcase
  endtask

  task automatic random_phase();
    int sent;
    sent = 0;
    while (sent < PHASE_BYTES) begin
      make_body();
      sent += body.size();
      send_body();
    end
  endtask

  initial begin
    logic [7:0] settings[$];
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    tx_burst    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty text
    load_text("");
    body.push_back(CH_NUL);
    send_body();
    // non-brace start
    load_text("q");
    send_body();
    // trailing comma before the close
    load_text("{\"\":1,}");
    send_body();
    // key left open when the body ends
    load_text("{\"k");
    send_body();
    // body ends right after the colon
    load_text("{\"\":");
    send_body();
    // end of text as a value, then an ignored byte
    load_text("{\"\":");
    body.push_back(CH_NUL);
    body.push_back("x");
    send_body();

    settings = '{8'd1, 8'd255, 8'd2, 8'd3, 8'd5, 8'($urandom_range(1, 255))};
    foreach (settings[i]) begin
      set_pair_limit(settings[i]);
      random_phase();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fails == 0)
      $display("flat_json_pair_tokenizer_core verification clean");
    else
      $display("flat_json_pair_tokenizer_core verification failed");
    $finish;
  end

endmodule

### flat_json_pair_tokenizer_core.f
rtl/core/fjt_pkg.sv
rtl/core/fjt_cfg.sv
rtl/core/fjt_parser.sv
rtl/core/fjt_out_queue.sv
rtl/core/flat_json_pair_tokenizer_core.sv
tb/fjt_checker.sv
tb/tb_flat_json_pair_tokenizer_core.sv
